[src/blwc_pkg.sv]
package blwc_pkg;

    // Sizes of the position row and of the query fields.
    localparam int MAX_POSITIONS = 32;
    localparam int MAX_STEPS     = 255;
    localparam int COUNT_WIDTH   = 32;
    localparam int LEN_WIDTH     = 6;
    localparam int STEP_WIDTH    = 8;
    localparam int POS_IDX_WIDTH = $clog2(MAX_POSITIONS);

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_READ,
        ST_DONE
    } state_t;

    // Commands from the sequencer to every cell of the row.
    typedef struct packed {
        logic load;
        logic step;
    } cell_ctrl_t;

endpackage

[src/blwc_cell.sv]
module blwc_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  blwc_pkg::cell_ctrl_t              ctrl,
    input  logic                              seed,
    input  logic                              active,
    input  logic [blwc_pkg::COUNT_WIDTH-1:0]  left_count,
    input  logic [blwc_pkg::COUNT_WIDTH-1:0]  right_count,
    output logic [blwc_pkg::COUNT_WIDTH-1:0]  count
);
    import blwc_pkg::*;

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    // A load clears the cell or seeds a single walk at the target. A step
    // sums both neighbors; an end position sees a zero neighbor outside the
    // line, and positions past the line length hold their zero.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.load)
        begin
            count_next = {{(COUNT_WIDTH-1){1'b0}}, seed};
        end
        else if (ctrl.step && active)
        begin
            count_next = left_count + right_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

[src/blwc_ctrl.sv]
module blwc_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [blwc_pkg::LEN_WIDTH-1:0]      line_length,
    input  logic [blwc_pkg::LEN_WIDTH-1:0]      start_position,
    input  logic [blwc_pkg::STEP_WIDTH-1:0]     step_count,
    input  logic [blwc_pkg::LEN_WIDTH-1:0]      target_position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [blwc_pkg::COUNT_WIDTH-1:0]    walk_count,
    output logic                                invalid_args,
    input  logic [blwc_pkg::COUNT_WIDTH-1:0]    start_count,
    output blwc_pkg::cell_ctrl_t                cell_ctrl,
    output logic [blwc_pkg::LEN_WIDTH-1:0]      active_len,
    output logic [blwc_pkg::POS_IDX_WIDTH-1:0]  start_idx
);
    import blwc_pkg::*;

    state_t                 state_reg;
    state_t                 state_next;
    logic [STEP_WIDTH-1:0]  steps_left_reg;
    logic [STEP_WIDTH-1:0]  steps_left_next;
    logic [LEN_WIDTH-1:0]   len_reg;
    logic [LEN_WIDTH-1:0]   len_next;
    logic [LEN_WIDTH-1:0]   start_reg;
    logic [LEN_WIDTH-1:0]   start_next;
    logic [COUNT_WIDTH-1:0] walk_count_reg;
    logic [COUNT_WIDTH-1:0] walk_count_next;
    logic                   invalid_reg;
    logic                   invalid_next;
    logic                   accept;
    logic                   args_bad;

    // Range checks on the incoming word.
    always_comb
    begin
        args_bad = (line_length < LEN_WIDTH'(2))
                || (line_length > LEN_WIDTH'(MAX_POSITIONS))
                || (step_count < STEP_WIDTH'(1))
                || (step_count > STEP_WIDTH'(MAX_STEPS))
                || (start_position < LEN_WIDTH'(1))
                || (start_position > line_length)
                || (target_position < LEN_WIDTH'(1))
                || (target_position > line_length);
    end

    assign accept = in_valid && (state_reg == ST_IDLE);

    // Next state, row commands and result register.
    always_comb
    begin
        state_next      = state_reg;
        steps_left_next = steps_left_reg;
        len_next        = len_reg;
        start_next      = start_reg;
        walk_count_next = walk_count_reg;
        invalid_next    = invalid_reg;
        cell_ctrl.load  = 1'b0;
        cell_ctrl.step  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (args_bad)
                    begin
                        walk_count_next = '0;
                        invalid_next    = 1'b1;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        cell_ctrl.load  = 1'b1;
                        steps_left_next = step_count;
                        len_next        = line_length;
                        start_next      = start_position;
                        state_next      = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                cell_ctrl.step  = 1'b1;
                steps_left_next = steps_left_reg - STEP_WIDTH'(1);
                if (steps_left_reg == STEP_WIDTH'(1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                walk_count_next = start_count;
                invalid_next    = 1'b0;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            steps_left_reg <= '0;
            len_reg        <= '0;
            start_reg      <= '0;
            invalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            steps_left_reg <= steps_left_next;
            len_reg        <= len_next;
            start_reg      <= start_next;
            invalid_reg    <= invalid_next;
        end
    end

    // Result data needs no reset; it is only shown with out_valid.
    always_ff @(posedge clk)
    begin
        walk_count_reg <= walk_count_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = (state_reg == ST_DONE);
    assign walk_count   = walk_count_reg;
    assign invalid_args = invalid_reg;
    assign active_len   = len_reg;
    assign start_idx    = POS_IDX_WIDTH'(start_reg - LEN_WIDTH'(1));

endmodule

[src/bounded_line_walk_counter_top.sv]
// Channel  Direction  Handshake          Fields
// in       input      in_valid/in_stall  line_length, start_position, step_count,
//                                        target_position
// out      output     out_valid/out_stall walk_count, invalid_args
//
// A valid query runs one update round per cycle across the row of position
// cells, one round per step, then registers the start position's count as its
// result word. A bad query shows its flagged word on the next cycle. One query
// is in flight at a time: in_stall stays high until the result word is taken.
// out_stall holds the result steady. Reset is asynchronous and clears the
// position counts; the result register has no reset.
module bounded_line_walk_counter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [blwc_pkg::LEN_WIDTH-1:0]      line_length,
    input  logic [blwc_pkg::LEN_WIDTH-1:0]      start_position,
    input  logic [blwc_pkg::STEP_WIDTH-1:0]     step_count,
    input  logic [blwc_pkg::LEN_WIDTH-1:0]      target_position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [blwc_pkg::COUNT_WIDTH-1:0]    walk_count,
    output logic                                invalid_args
);
    import blwc_pkg::*;

    logic [COUNT_WIDTH-1:0]   counts [MAX_POSITIONS];
    cell_ctrl_t               cell_ctrl;
    logic [LEN_WIDTH-1:0]     active_len;
    logic [POS_IDX_WIDTH-1:0] start_idx;
    logic [COUNT_WIDTH-1:0]   start_count;

    // Sequencer: handshakes, round counter and result register.
    blwc_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .line_length     (line_length),
        .start_position  (start_position),
        .step_count      (step_count),
        .target_position (target_position),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .walk_count      (walk_count),
        .invalid_args    (invalid_args),
        .start_count     (start_count),
        .cell_ctrl       (cell_ctrl),
        .active_len      (active_len),
        .start_idx       (start_idx)
    );

    // Row of position cells, each fed by its two neighbors.
    for (genvar j = 0; j < MAX_POSITIONS; j++)
    begin : g_cell
        localparam logic [LEN_WIDTH-1:0] POS = LEN_WIDTH'(j + 1);
        logic [COUNT_WIDTH-1:0] left_count;
        logic [COUNT_WIDTH-1:0] right_count;

        if (j == 0)
        begin : g_first
            assign left_count = '0;
        end
        else
        begin : g_inner_left
            assign left_count = counts[j-1];
        end

        if (j == MAX_POSITIONS - 1)
        begin : g_last
            assign right_count = '0;
        end
        else
        begin : g_inner_right
            assign right_count = counts[j+1];
        end

        blwc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .seed        (target_position == POS),
            .active      (POS <= active_len),
            .left_count  (left_count),
            .right_count (right_count),
            .count       (counts[j])
        );
    end

    // Pick the count held at the start position.
    assign start_count = counts[start_idx];

endmodule

[src/blwc_checker.sv]
module blwc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [blwc_pkg::LEN_WIDTH-1:0]      line_length,
    input  logic [blwc_pkg::LEN_WIDTH-1:0]      start_position,
    input  logic [blwc_pkg::STEP_WIDTH-1:0]     step_count,
    input  logic [blwc_pkg::LEN_WIDTH-1:0]      target_position,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [blwc_pkg::COUNT_WIDTH-1:0]    walk_count,
    input  logic                                invalid_args
);
    import blwc_pkg::*;

    logic in_bad;

    assign in_bad = (line_length < LEN_WIDTH'(2))
                 || (line_length > LEN_WIDTH'(MAX_POSITIONS))
                 || (step_count == '0)
                 || (start_position == '0)
                 || (start_position > line_length)
                 || (target_position == '0)
                 || (target_position > line_length);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(walk_count)
            && $stable(invalid_args))
        else $error("result word changed while stalled");

    // A rejected query reports a zero count.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid_args |-> walk_count == '0)
        else $error("invalid query with nonzero count");

    // After a word is accepted the input side stalls.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word accepted while busy");

    // A bad query gives its flagged result on the next cycle.
    a_bad_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_bad |=> out_valid && invalid_args)
        else $error("bad query not flagged");

endmodule

bind bounded_line_walk_counter_top blwc_checker u_blwc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .line_length     (line_length),
    .start_position  (start_position),
    .step_count      (step_count),
    .target_position (target_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .walk_count      (walk_count),
    .invalid_args    (invalid_args)
);
